FILE: hdl/v4au_pkg.sv
package v4au_pkg;

  localparam int NUM_ELEM = 4;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 64;
  localparam int WIDE_W   = 66;
  localparam int ROOT_W   = 33;
  localparam int REM_W    = 35;
  localparam int SQRT_STAGES = ROOT_W;

  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_SUB    = 3'd1;
  localparam logic [2:0] FN_SCALE  = 3'd2;
  localparam logic [2:0] FN_DOT3   = 3'd3;
  localparam logic [2:0] FN_CROSS3 = 3'd4;
  localparam logic [2:0] FN_LENGTH = 3'd5;
  localparam logic [2:0] FN_NORM   = 3'd6;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [2:0]                          func;
    logic                                err;
    logic [NUM_ELEM-1:0][DATA_W-1:0]     vec;
    logic [DATA_W-1:0]                   scalar;
    logic [NUM_ELEM-1:0]                 neg;
    logic [NUM_ELEM-1:0][DATA_W-1:0]     mag;
  } pkt_t;

  // {overflow, clamped value}
  function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [DATA_W:0] r;
    if (v[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){v[DATA_W-1]}}) begin
      r = {1'b1, v[WIDE_W-1] ? 32'h8000_0000 : 32'h7fff_ffff};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sext_prod(input logic signed [PROD_W-1:0] p);
    return {{(WIDE_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

FILE: hdl/vector4_arithmetic_unit.sv
// Four-element signed fixed-point vector ALU (add, sub, scale, dot3, cross3,
// length, normalize), saturating with an error flag. Fully pipelined: one
// beat is accepted every cycle while the output is not stalled. The depth is
// set by the 33-stage square-root pipeline followed by the FRAC_BITS + 1
// stage normalize dividers, plus the multiplier, merge and output registers.
// All operations pass through the same pipeline.
// A stalled output freezes the whole pipeline; in_stall_o is high only while
// the output register holds a beat that out_stall_i is refusing.
module vector4_arithmetic_unit import v4au_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  word_t       a_elem0_i,
  input  word_t       a_elem1_i,
  input  word_t       a_elem2_i,
  input  word_t       a_elem3_i,
  input  word_t       b_elem0_i,
  input  word_t       b_elem1_i,
  input  word_t       b_elem2_i,
  input  word_t       b_elem3_i,
  input  word_t       scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output word_t       r_elem0_o,
  output word_t       r_elem1_o,
  output word_t       r_elem2_o,
  output word_t       r_elem3_o,
  output word_t       scalar_out_o,
  output logic        error_flag_o
);

  logic en;
  word_t a_w [NUM_ELEM];
  word_t b_w [NUM_ELEM];
  logic signed [PROD_W-1:0] p_w [NUM_ELEM];
  logic signed [PROD_W-1:0] q_w [NUM_ELEM];
  logic signed [DATA_W:0]   sum_w [NUM_ELEM];

  logic        v1_q, v2_q, out_vld_q;
  logic [2:0]  func1_q;
  logic [NUM_ELEM-1:0][DATA_W-1:0] a1_q;
  pkt_t        pkt_d, pkt2_q, sq_pkt, dv_pkt, out_d, out_q;
  logic [WIDE_W-1:0] rad_d, rad2_q;
  logic        sq_vld, dv_vld;
  logic [ROOT_W-1:0] sq_root, dv_len;
  logic [NUM_ELEM-1:0][FRAC_BITS:0] quot;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  assign a_w[0] = a_elem0_i;
  assign a_w[1] = a_elem1_i;
  assign a_w[2] = a_elem2_i;
  assign a_w[3] = a_elem3_i;
  assign b_w[0] = b_elem0_i;
  assign b_w[1] = b_elem1_i;
  assign b_w[2] = b_elem2_i;
  assign b_w[3] = b_elem3_i;

  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
    v4au_lane #(.LANE(i)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .func_i (func_i),
      .a_i    (a_w),
      .b_i    (b_w),
      .s_i    (scale_i),
      .p_o    (p_w[i]),
      .q_o    (q_w[i]),
      .sum_o  (sum_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q <= func_i;
      a1_q    <= {a_elem3_i, a_elem2_i, a_elem1_i, a_elem0_i};
      pkt2_q  <= pkt_d;
      rad2_q  <= rad_d;
      out_q   <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= in_valid_i && !in_stall_o;
      v2_q      <= v1_q;
      out_vld_q <= dv_vld;
    end
  end

  // merge: combine lane products and sums into saturated results, or into the radicand for length and normalize
  always_comb begin
    logic [DATA_W:0] r;
    logic signed [WIDE_W-1:0] w;
    r          = '0;
    w          = '0;
    pkt_d      = '0;
    pkt_d.func = func1_q;
    rad_d      = '0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      pkt_d.neg[i] = a1_q[i][DATA_W-1];
      pkt_d.mag[i] = a1_q[i][DATA_W-1] ? DATA_W'(0) - a1_q[i] : a1_q[i];
    end
    case (func1_q)
      FN_ADD, FN_SUB: begin
        for (int i = 0; i < NUM_ELEM; i++) begin
          r = sat32({{(WIDE_W-DATA_W-1){sum_w[i][DATA_W]}}, sum_w[i]});
          pkt_d.vec[i] = r[DATA_W-1:0];
          pkt_d.err    = pkt_d.err | r[DATA_W];
        end
      end
      FN_SCALE: begin
        for (int i = 0; i < NUM_ELEM; i++) begin
          r = sat32(sext_prod(p_w[i]) >>> FRAC_BITS);
          pkt_d.vec[i] = r[DATA_W-1:0];
          pkt_d.err    = pkt_d.err | r[DATA_W];
        end
      end
      FN_DOT3: begin
        w = sext_prod(p_w[0]) + sext_prod(p_w[1]) + sext_prod(p_w[2]);
        r = sat32(w >>> FRAC_BITS);
        pkt_d.scalar = r[DATA_W-1:0];
        pkt_d.err    = r[DATA_W];
      end
      FN_CROSS3: begin
        for (int i = 0; i < 3; i++) begin
          w = sext_prod(p_w[i]) - sext_prod(q_w[i]);
          r = sat32(w >>> FRAC_BITS);
          pkt_d.vec[i] = r[DATA_W-1:0];
          pkt_d.err    = pkt_d.err | r[DATA_W];
        end
        pkt_d.vec[3] = a1_q[3];
      end
      FN_LENGTH, FN_NORM: begin
        // squares are nonnegative, their sum fits 65 bits
        rad_d = WIDE_W'(p_w[0]) + WIDE_W'(p_w[1]) + WIDE_W'(p_w[2]) + WIDE_W'(p_w[3]);
      end
      default: ;
    endcase
  end

  v4au_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .pkt_i   (pkt2_q),
    .rad_i   (rad2_q),
    .valid_o (sq_vld),
    .pkt_o   (sq_pkt),
    .root_o  (sq_root)
  );

  v4au_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .pkt_i   (sq_pkt),
    .len_i   (sq_root),
    .valid_o (dv_vld),
    .pkt_o   (dv_pkt),
    .len_o   (dv_len),
    .quot_o  (quot)
  );

  always_comb begin
    logic [DATA_W:0]  r;
    logic [DATA_W-1:0] qx;
    qx    = '0;
    out_d = dv_pkt;
    r     = sat32({{(WIDE_W-ROOT_W){1'b0}}, dv_len});
    case (dv_pkt.func)
      FN_LENGTH: begin
        out_d.scalar = r[DATA_W-1:0];
        out_d.err    = r[DATA_W];
      end
      FN_NORM: begin
        if (dv_len == '0) begin
          out_d.err = 1'b1;
        end else begin
          for (int i = 0; i < NUM_ELEM; i++) begin
            qx = DATA_W'(quot[i]);
            out_d.vec[i] = dv_pkt.neg[i] ? DATA_W'(0) - qx : qx;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_vld_q;
  assign r_elem0_o    = out_q.vec[0];
  assign r_elem1_o    = out_q.vec[1];
  assign r_elem2_o    = out_q.vec[2];
  assign r_elem3_o    = out_q.vec[3];
  assign scalar_out_o = out_q.scalar;
  assign error_flag_o = out_q.err;

endmodule

FILE: hdl/v4au_lane.sv
module v4au_lane import v4au_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [2:0]                func_i,
  input  word_t                     a_i [NUM_ELEM],
  input  word_t                     b_i [NUM_ELEM],
  input  word_t                     s_i,
  output logic signed [PROD_W-1:0]  p_o,
  output logic signed [PROD_W-1:0]  q_o,
  output logic signed [DATA_W:0]    sum_o
);

  // cross product operand indexes
  localparam int J = (LANE + 1) % 3;
  localparam int K = (LANE + 2) % 3;

  word_t px, py, qx, qy;
  logic signed [DATA_W:0] sum_d;

  always_comb begin
    qx = a_i[K];
    qy = b_i[J];
    px = a_i[LANE];
    py = b_i[LANE];
    case (func_i)
      FN_SCALE:  py = s_i;
      FN_CROSS3: begin
        px = a_i[J];
        py = b_i[K];
      end
      FN_LENGTH, FN_NORM: py = a_i[LANE];
      default: ;
    endcase
    if (func_i == FN_SUB) begin
      sum_d = (DATA_W+1)'(a_i[LANE]) - (DATA_W+1)'(b_i[LANE]);
    end else begin
      sum_d = (DATA_W+1)'(a_i[LANE]) + (DATA_W+1)'(b_i[LANE]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o   <= PROD_W'(px) * PROD_W'(py);
      q_o   <= PROD_W'(qx) * PROD_W'(qy);
      sum_o <= sum_d;
    end
  end

endmodule

FILE: hdl/v4au_isqrt.sv
module v4au_isqrt import v4au_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pkt_t              pkt_i,
  input  logic [WIDE_W-1:0] rad_i,
  output logic              valid_o,
  output pkt_t              pkt_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              vld  [SQRT_STAGES+1];
  pkt_t              pkt  [SQRT_STAGES+1];
  logic [WIDE_W-1:0] rad  [SQRT_STAGES+1];
  logic [REM_W-1:0]  rem  [SQRT_STAGES+1];
  logic [ROOT_W-1:0] root [SQRT_STAGES+1];

  assign vld[0]  = valid_i;
  assign pkt[0]  = pkt_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  // one root bit per stage, radicand consumed two bits at a time from the top
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [REM_W+1:0] cur, trial, diff;
    logic             ge;

    assign cur   = {rem[k], rad[k][WIDE_W-1 -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pkt[k+1]  <= pkt[k];
        rad[k+1]  <= {rad[k][WIDE_W-3:0], 2'b00};
        rem[k+1]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root[k+1] <= {root[k][ROOT_W-2:0], ge};
      end
    end
  end

  assign valid_o = vld[SQRT_STAGES];
  assign pkt_o   = pkt[SQRT_STAGES];
  assign root_o  = root[SQRT_STAGES];

endmodule

FILE: hdl/v4au_div.sv
module v4au_div import v4au_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  pkt_t                              pkt_i,
  input  logic [ROOT_W-1:0]                 len_i,
  output logic                              valid_o,
  output pkt_t                              pkt_o,
  output logic [ROOT_W-1:0]                 len_o,
  output logic [NUM_ELEM-1:0][FRAC_BITS:0]  quot_o
);

  localparam int STEPS = FRAC_BITS + 1;

  logic                             vld  [STEPS+1];
  pkt_t                             pkt  [STEPS+1];
  logic [ROOT_W-1:0]                len  [STEPS+1];
  logic [NUM_ELEM-1:0][ROOT_W-1:0]  rem  [STEPS+1];
  logic [NUM_ELEM-1:0][FRAC_BITS:0] quot [STEPS+1];

  assign vld[0]  = valid_i;
  assign pkt[0]  = pkt_i;
  assign len[0]  = len_i;
  assign quot[0] = '0;

  // quotient never exceeds 2^FRAC_BITS, so start from mag/2
  for (genvar l = 0; l < NUM_ELEM; l++) begin : g_init
    assign rem[0][l] = {2'b00, pkt_i.mag[l][DATA_W-1:1]};
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [NUM_ELEM-1:0][ROOT_W-1:0] rem_d;
    logic [NUM_ELEM-1:0]             qbit;

    for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
      logic [ROOT_W:0] cur, diff;
      logic            nbit;
      assign nbit    = (s == 0) ? pkt[s].mag[l][0] : 1'b0;
      assign cur     = {rem[s][l], nbit};
      assign diff    = cur - {1'b0, len[s]};
      assign qbit[l] = cur >= {1'b0, len[s]};
      assign rem_d[l] = qbit[l] ? diff[ROOT_W-1:0] : cur[ROOT_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pkt[s+1] <= pkt[s];
        len[s+1] <= len[s];
        rem[s+1] <= rem_d;
        for (int l = 0; l < NUM_ELEM; l++) begin
          quot[s+1][l] <= {quot[s][l][FRAC_BITS-1:0], qbit[l]};
        end
      end
    end
  end

  assign valid_o = vld[STEPS];
  assign pkt_o   = pkt[STEPS];
  assign len_o   = len[STEPS];
  assign quot_o  = quot[STEPS];

endmodule
